// ===== design/pls_pkg.sv =====
// ----------------------------------------------------------------------------
// pls_pkg
// Shared types and constants for the positional list store: field widths,
// operation and status codes, cell commands and controller states.
// ----------------------------------------------------------------------------
package pls_pkg;

   localparam int DEPTH_DEF = 16;

   localparam int MODE_W  = 3;
   localparam int POS_W   = 5;
   localparam int DATA_W  = 32;
   localparam int STAT_W  = 2;
   localparam int COUNT_W = 5;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH_FRONT = 3'd0,
      MODE_PUSH_BACK  = 3'd1,
      MODE_INSERT_AT  = 3'd2,
      MODE_POP_FRONT  = 3'd3,
      MODE_POP_BACK   = 3'd4,
      MODE_REMOVE_AT  = 3'd5,
      MODE_LIST_ALL   = 3'd6
   } pls_mode_type;

   typedef enum logic [STAT_W-1:0] {
      STATUS_DONE   = 2'd0,
      STATUS_BADPOS = 2'd1,
      STATUS_FULL   = 2'd2,
      STATUS_EMPTY  = 2'd3
   } pls_status_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_REMOVE = 2'd2,
      CELL_ROTATE = 2'd3
   } pls_cell_op_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_LIST = 1'b1
   } pls_state_type;

endpackage

// ===== design/positional_list_store.sv =====
// A single-word result is registered at the edge that takes its request and can
// be taken from the next cycle on; list all registers its words from the list state.
// Throughput: one request per cycle, while the output is free, for every mode but
// list all, which holds the input until its last word, rotating the row once per word.
// Reset clears the element count, the controller state and the result valid;
// the cell contents are undefined until written.
// ----------------------------------------------------------------------------
// positional_list_store
// Bounded ordered list of signed words held in a row of cells, front first,
// with push, insert, pop, remove and full listing by position.
// ----------------------------------------------------------------------------
module positional_list_store #(
   parameter int DEPTH = pls_pkg::DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [pls_pkg::MODE_W-1:0]    req_mode,
   input  logic [pls_pkg::POS_W-1:0]     req_position,
   input  logic signed [pls_pkg::DATA_W-1:0] req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [pls_pkg::STAT_W-1:0]    rsp_status,
   output logic signed [pls_pkg::DATA_W-1:0] rsp_element,
   output logic [pls_pkg::COUNT_W-1:0]   rsp_count,
   output logic                          rsp_last
);
   import pls_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   pls_cell_op_type   cell_op;
   logic [IDX_W-1:0]  cell_idx;
   logic [DATA_W-1:0] cell_q [DEPTH];
   logic [DATA_W-1:0] pick_word;
   logic [DATA_W-1:0] element_w;

   assign pick_word   = cell_q[cell_idx];
   assign rsp_element = element_w;

   pls_ctrl #(
      .DEPTH (DEPTH),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_mode     (req_mode),
      .req_position (req_position),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_status   (rsp_status),
      .rsp_element  (element_w),
      .rsp_count    (rsp_count),
      .rsp_last     (rsp_last),
      .cell_op      (cell_op),
      .cell_idx     (cell_idx),
      .front_word   (cell_q[0]),
      .pick_word    (pick_word)
   );

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [DATA_W-1:0] prev_w;
      logic [DATA_W-1:0] next_w;

      if (g == 0) begin : g_first
         assign prev_w = cell_q[g];
      end else begin : g_mid_prev
         assign prev_w = cell_q[g-1];
      end

      if (g == DEPTH - 1) begin : g_tail
         assign next_w = cell_q[g];
      end else begin : g_mid_next
         assign next_w = cell_q[g+1];
      end

      pls_cell #(
         .INDEX (g),
         .IDX_W (IDX_W)
      ) u_cell (
         .clock      (clock),
         .cell_op    (cell_op),
         .cell_idx   (cell_idx),
         .new_word   (req_value),
         .prev_word  (prev_w),
         .next_word  (next_w),
         .front_word (cell_q[0]),
         .entry      (cell_q[g])
      );
   end

endmodule

// ===== design/pls_cell.sv =====
// ----------------------------------------------------------------------------
// pls_cell
// One place of the list. Compares its own position with the broadcast index
// and takes its next value from the word in front, the word behind, the new
// word or the front of the list.
// ----------------------------------------------------------------------------
module pls_cell #(
   parameter int INDEX = 0,
   parameter int IDX_W = 4
) (
   input  logic                         clock,
   input  pls_pkg::pls_cell_op_type     cell_op,
   input  logic [IDX_W-1:0]             cell_idx,
   input  logic [pls_pkg::DATA_W-1:0]   new_word,
   input  logic [pls_pkg::DATA_W-1:0]   prev_word,
   input  logic [pls_pkg::DATA_W-1:0]   next_word,
   input  logic [pls_pkg::DATA_W-1:0]   front_word,
   output logic [pls_pkg::DATA_W-1:0]   entry
);
   import pls_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic [DATA_W-1:0] entry_ff;
   logic [DATA_W-1:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      case (cell_op)
         CELL_INSERT: begin
            if (MY_IDX == cell_idx) begin
               entry_in = new_word;
            end else if (MY_IDX > cell_idx) begin
               entry_in = prev_word;
            end
         end
         CELL_REMOVE: begin
            if (MY_IDX >= cell_idx) begin
               entry_in = next_word;
            end
         end
         CELL_ROTATE: begin
            // The front word wraps round to the last occupied place.
            if (MY_IDX == cell_idx) begin
               entry_in = front_word;
            end else if (MY_IDX < cell_idx) begin
               entry_in = next_word;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== design/pls_ctrl.sv =====
// ----------------------------------------------------------------------------
// pls_ctrl
// Decodes each request into a command for the cell row, keeps the element
// count, walks the row during a full listing and holds the result register.
// ----------------------------------------------------------------------------
module pls_ctrl #(
   parameter int DEPTH = pls_pkg::DEPTH_DEF,
   parameter int IDX_W = $clog2(DEPTH),
   parameter int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [pls_pkg::MODE_W-1:0]    req_mode,
   input  logic [pls_pkg::POS_W-1:0]     req_position,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [pls_pkg::STAT_W-1:0]    rsp_status,
   output logic [pls_pkg::DATA_W-1:0]    rsp_element,
   output logic [pls_pkg::COUNT_W-1:0]   rsp_count,
   output logic                          rsp_last,
   output pls_pkg::pls_cell_op_type      cell_op,
   output logic [IDX_W-1:0]              cell_idx,
   input  logic [pls_pkg::DATA_W-1:0]    front_word,
   input  logic [pls_pkg::DATA_W-1:0]    pick_word
);
   import pls_pkg::*;

   localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   pls_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  remain_ff, remain_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic [DATA_W-1:0] element_ff, element_in;
   logic              last_ff, last_in;

   logic              out_free;
   logic              accept;
   logic              full;
   logic              empty;
   logic [CMP_W-1:0]  pos_c;
   logic [CMP_W-1:0]  cnt_c;
   logic [CMP_W-1:0]  pos_m1;
   logic [IDX_W-1:0]  last_idx;

   pls_cell_op_type   dec_op;
   logic [IDX_W-1:0]  dec_idx;
   pls_status_type    dec_status;
   logic [DATA_W-1:0] dec_element;
   logic [CNT_W-1:0]  dec_count;
   logic              dec_list;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign accept   = req_valid && req_ready;
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pos_c    = CMP_W'(req_position);
   assign cnt_c    = CMP_W'(count_ff);
   assign pos_m1   = pos_c - CMP_W'(1);
   assign last_idx = IDX_W'(count_ff - CNT_W'(1));

   // Request decode: status, row command and count after the operation.
   always_comb begin
      dec_op      = CELL_HOLD;
      dec_idx     = '0;
      dec_status  = STATUS_DONE;
      dec_element = '0;
      dec_count   = count_ff;
      dec_list    = 1'b0;
      case (req_mode)
         MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
            if (full) begin
               dec_status = STATUS_FULL;
            end else begin
               dec_op    = CELL_INSERT;
               dec_idx   = (req_mode == MODE_PUSH_FRONT) ? '0 : IDX_W'(count_ff);
               dec_count = count_ff + CNT_W'(1);
            end
         end
         MODE_INSERT_AT: begin
            if (pos_c == '0 || pos_c > cnt_c + CMP_W'(1)) begin
               dec_status = STATUS_BADPOS;
            end else if (full) begin
               dec_status = STATUS_FULL;
            end else begin
               dec_op    = CELL_INSERT;
               dec_idx   = pos_m1[IDX_W-1:0];
               dec_count = count_ff + CNT_W'(1);
            end
         end
         MODE_POP_FRONT, MODE_POP_BACK, MODE_REMOVE_AT: begin
            if (empty) begin
               dec_status = STATUS_EMPTY;
            end else if (req_mode == MODE_REMOVE_AT &&
                         (pos_c == '0 || pos_c > cnt_c)) begin
               dec_status = STATUS_BADPOS;
            end else begin
               dec_op = CELL_REMOVE;
               if (req_mode == MODE_POP_FRONT) begin
                  dec_idx = '0;
               end else if (req_mode == MODE_POP_BACK) begin
                  dec_idx = last_idx;
               end else begin
                  dec_idx = pos_m1[IDX_W-1:0];
               end
               dec_element = pick_word;
               dec_count   = count_ff - CNT_W'(1);
            end
         end
         MODE_LIST_ALL: begin
            if (empty) begin
               dec_status = STATUS_EMPTY;
            end else begin
               dec_list = 1'b1;
            end
         end
         default: begin
            dec_status = STATUS_DONE;
         end
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && dec_list) begin
               state_in = ST_LIST;
            end
         end
         ST_LIST: begin
            if (out_free && remain_ff == CNT_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs and datapath updates.
   always_comb begin
      req_ready    = 1'b0;
      cell_op      = CELL_HOLD;
      cell_idx     = '0;
      count_in     = count_ff;
      remain_in    = remain_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      element_in   = element_ff;
      last_in      = last_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = out_free;
            if (accept) begin
               if (dec_list) begin
                  remain_in = count_ff;
               end else begin
                  cell_op      = dec_op;
                  cell_idx     = dec_idx;
                  count_in     = dec_count;
                  rsp_valid_in = 1'b1;
                  status_in    = dec_status;
                  element_in   = dec_element;
                  last_in      = 1'b1;
               end
            end
         end
         ST_LIST: begin
            // Each word sent rotates the row by one, so after the whole
            // listing the list stands as before.
            if (out_free) begin
               cell_op      = CELL_ROTATE;
               cell_idx     = last_idx;
               remain_in    = remain_ff - CNT_W'(1);
               rsp_valid_in = 1'b1;
               status_in    = STATUS_DONE;
               element_in   = front_word;
               last_in      = (remain_ff == CNT_W'(1));
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      element_ff <= element_in;
      last_ff    <= last_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = status_ff;
   assign rsp_element = element_ff;
   assign rsp_count   = COUNT_W'(count_ff);
   assign rsp_last    = last_ff;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the positional list store. A short table of
// directed requests opens the run, and phases of random requests follow,
// each with its own bias between filling and draining. Every result word
// is compared field by field with the table or a shadow list in the bench.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pls_pkg::*;

   localparam int DEPTH       = DEPTH_DEF;
   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD   = 60;
   localparam int PHASES      = 6;
   localparam int PHASE_ITEMS = 24;
   localparam int DIR_ROWS    = 25;

   // Mode 7 has no meaning and is answered with a plain done word.
   localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [DATA_W-1:0]  element;
      logic [COUNT_W-1:0] count;
      logic               last;
   } rsp_word_type;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [POS_W-1:0]   pos;
      logic [DATA_W-1:0]  val;
      logic               typed;
      logic [STAT_W-1:0]  status;
      logic [DATA_W-1:0]  element;
      logic [COUNT_W-1:0] count;
   } dir_row_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [MODE_W-1:0]         req_mode;
   logic [POS_W-1:0]          req_position;
   logic signed [DATA_W-1:0]  req_value;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic [STAT_W-1:0]         rsp_status;
   logic signed [DATA_W-1:0]  rsp_element;
   logic [COUNT_W-1:0]        rsp_count;
   logic                      rsp_last;

   // Shadow of the list and the words it is owed.
   logic [DATA_W-1:0] shadow_list [DEPTH];
   int                shadow_fill = 0;
   rsp_word_type      owed_words [$];

   // The word that travels with the request now on offer.
   logic         row_typed = 1'b0;
   rsp_word_type row_word  = '0;

   int  errors      = 0;
   int  requests    = 0;
   int  words_seen  = 0;
   int  list_walks  = 0;
   int  full_refuse = 0;
   int  peak_fill   = 0;
   int  burst_left  = 0;
   bit  hold_req    = 1'b0;

   int phase_bias [PHASES] = '{85, 50, 15, 85, 30, 60};

   dir_row_type dir_rows [DIR_ROWS] = '{
      '{MODE_POP_FRONT,  5'd0,  32'h0000_0000, 1'b1, STATUS_EMPTY,  32'h0, 5'd0},
      '{MODE_POP_BACK,   5'd31, 32'hFFFF_FFFF, 1'b1, STATUS_EMPTY,  32'h0, 5'd0},
      '{MODE_REMOVE_AT,  5'd1,  32'h0000_0000, 1'b1, STATUS_EMPTY,  32'h0, 5'd0},
      '{MODE_REMOVE_AT,  5'd0,  32'h0000_0000, 1'b1, STATUS_EMPTY,  32'h0, 5'd0},
      '{MODE_LIST_ALL,   5'd0,  32'h0000_0000, 1'b1, STATUS_EMPTY,  32'h0, 5'd0},
      '{MODE_INSERT_AT,  5'd0,  32'h0000_0005, 1'b1, STATUS_BADPOS, 32'h0, 5'd0},
      '{MODE_INSERT_AT,  5'd2,  32'h0000_0005, 1'b1, STATUS_BADPOS, 32'h0, 5'd0},
      '{MODE_INSERT_AT,  5'd1,  32'h7FFF_FFFF, 1'b1, STATUS_DONE,   32'h0, 5'd1},
      '{MODE_PUSH_FRONT, 5'd0,  32'h8000_0000, 1'b1, STATUS_DONE,   32'h0, 5'd2},
      '{MODE_PUSH_BACK,  5'd31, 32'h0000_0000, 1'b1, STATUS_DONE,   32'h0, 5'd3},
      '{MODE_UNUSED,     5'd31, 32'hFFFF_FFFF, 1'b1, STATUS_DONE,   32'h0, 5'd3},
      '{MODE_LIST_ALL,   5'd0,  32'h0000_0000, 1'b0, STATUS_DONE,   32'h0, 5'd0},
      '{MODE_REMOVE_AT,  5'd0,  32'h0000_0000, 1'b1, STATUS_BADPOS, 32'h0, 5'd3},
      '{MODE_REMOVE_AT,  5'd4,  32'h0000_0000, 1'b1, STATUS_BADPOS, 32'h0, 5'd3},
      '{MODE_INSERT_AT,  5'd31, 32'h0000_0001, 1'b1, STATUS_BADPOS, 32'h0, 5'd3},
      '{MODE_REMOVE_AT,  5'd2,  32'h0000_0000, 1'b0, STATUS_DONE,   32'h0, 5'd0},
      '{MODE_INSERT_AT,  5'd3,  32'hFFFF_FFFF, 1'b0, STATUS_DONE,   32'h0, 5'd0},
      '{MODE_INSERT_AT,  5'd1,  32'h5A5A_5A5A, 1'b0, STATUS_DONE,   32'h0, 5'd0},
      '{MODE_LIST_ALL,   5'd0,  32'h0000_0000, 1'b0, STATUS_DONE,   32'h0, 5'd0},
      '{MODE_POP_FRONT,  5'd0,  32'h0000_0000, 1'b0, STATUS_DONE,   32'h0, 5'd0},
      '{MODE_POP_BACK,   5'd0,  32'h0000_0000, 1'b0, STATUS_DONE,   32'h0, 5'd0},
      '{MODE_REMOVE_AT,  5'd1,  32'h0000_0000, 1'b0, STATUS_DONE,   32'h0, 5'd0},
      '{MODE_PUSH_FRONT, 5'd0,  32'h1234_5678, 1'b0, STATUS_DONE,   32'h0, 5'd0},
      '{MODE_LIST_ALL,   5'd0,  32'h0000_0000, 1'b0, STATUS_DONE,   32'h0, 5'd0},
      '{MODE_UNUSED,     5'd0,  32'h0000_0000, 1'b0, STATUS_DONE,   32'h0, 5'd0}
   };

   positional_list_store #(
      .DEPTH(DEPTH)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_mode     (req_mode),
      .req_position (req_position),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_status   (rsp_status),
      .rsp_element  (rsp_element),
      .rsp_count    (rsp_count),
      .rsp_last     (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      errors++;
      if (errors <= 40) begin
         $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
      end
   endtask

   // Applies one taken request to the shadow list and queues the words owed.
   task automatic apply_request(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] pos,
                                input logic [DATA_W-1:0] val, input logic typed,
                                input rsp_word_type typed_word);
      rsp_word_type w;
      int           at;
      bit           grow;
      bit           shrink;
      w      = '{STATUS_DONE, '0, '0, 1'b1};
      at     = 0;
      grow   = 1'b0;
      shrink = 1'b0;
      requests++;
      case (mode)
         MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
            if (shadow_fill >= DEPTH) begin
               w.status = STATUS_FULL;
            end else begin
               grow = 1'b1;
               at   = (mode == MODE_PUSH_FRONT) ? 0 : shadow_fill;
            end
         end
         MODE_INSERT_AT: begin
            // A bad position wins over a full list.
            if (pos < 1 || pos > shadow_fill + 1) begin
               w.status = STATUS_BADPOS;
            end else if (shadow_fill >= DEPTH) begin
               w.status = STATUS_FULL;
            end else begin
               grow = 1'b1;
               at   = pos - 1;
            end
         end
         MODE_POP_FRONT, MODE_POP_BACK, MODE_REMOVE_AT: begin
            // An empty list wins over a bad position.
            if (shadow_fill == 0) begin
               w.status = STATUS_EMPTY;
            end else if (mode == MODE_REMOVE_AT && (pos < 1 || pos > shadow_fill)) begin
               w.status = STATUS_BADPOS;
            end else begin
               shrink = 1'b1;
               at = (mode == MODE_POP_FRONT) ? 0 :
                    (mode == MODE_POP_BACK)  ? shadow_fill - 1 : pos - 1;
            end
         end
         MODE_LIST_ALL: begin
            list_walks++;
            if (shadow_fill == 0) w.status = STATUS_EMPTY;
         end
         default: ;
      endcase
      if (grow) begin
         for (int i = shadow_fill; i > at; i--) shadow_list[i] = shadow_list[i-1];
         shadow_list[at] = val;
         shadow_fill++;
      end
      if (shrink) begin
         w.element = shadow_list[at];
         for (int i = at; i + 1 < shadow_fill; i++) shadow_list[i] = shadow_list[i+1];
         shadow_fill--;
      end
      if (w.status == STATUS_FULL) full_refuse++;
      if (shadow_fill > peak_fill) peak_fill = shadow_fill;
      w.count = COUNT_W'(shadow_fill);
      if (typed) begin
         owed_words.push_back(typed_word);
      end else if (mode == MODE_LIST_ALL && shadow_fill != 0) begin
         for (int i = 0; i < shadow_fill; i++) begin
            w.element = shadow_list[i];
            w.last    = (i == shadow_fill - 1);
            owed_words.push_back(w);
         end
      end else begin
         owed_words.push_back(w);
      end
   endtask

   always @(posedge clock) begin : check_rsp
      rsp_word_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            apply_request(req_mode, req_position, req_value, row_typed, row_word);
         end
         if (rsp_valid && rsp_ready) begin
            if (owed_words.size() == 0) begin
               report_mismatch("word with nothing owed", rsp_element, '0);
            end else begin
               want = owed_words.pop_front();
               words_seen++;
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_element !== want.element)
                  report_mismatch("element", rsp_element, want.element);
               if (rsp_count !== want.count)
                  report_mismatch("count", rsp_count, want.count);
               if (rsp_last !== want.last)
                  report_mismatch("last", rsp_last, want.last);
            end
         end
      end
   end

   // Offers one request at a falling edge and returns at the falling edge
   // after it was taken. Requests come in bursts, mostly with idle gaps between.
   task automatic send_word(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] pos,
                            input logic [DATA_W-1:0] val, input logic typed,
                            input rsp_word_type typed_word);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
      end
      burst_left--;
      req_mode     = mode;
      req_position = pos;
      req_value    = val;
      row_typed    = typed;
      row_word     = typed_word;
      req_valid    = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid  = 1'b0;
      burst_left = 0;
      while (owed_words.size() != 0) @(negedge clock);
   endtask

   // The receiver keeps its own pattern of stalls, changing every stretch,
   // and on request holds off for a long run of cycles.
   initial begin : receiver
      int hold_left;
      int stretch;
      int ready_pct;
      bit hold_seen;
      rsp_ready = 1'b0;
      hold_left = 0;
      stretch   = 0;
      ready_pct = 100;
      hold_seen = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req && !hold_seen) begin
            hold_left = LONG_HOLD;
            hold_seen = 1'b1;
         end
         if (stretch == 0) begin
            stretch = $urandom_range(10, 60);
            case ($urandom_range(0, 3))
               0: ready_pct = 100;
               1: ready_pct = 70;
               2: ready_pct = 40;
               default: ready_pct = 15;
            endcase
         end
         stretch--;
         if (hold_left > 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else begin
            rsp_ready = ($urandom_range(0, 99) < ready_pct);
         end
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Timed out after %0d cycles", CYCLE_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   initial begin : stimulus
      dir_row_type       row;
      rsp_word_type      tw;
      logic [MODE_W-1:0] m;
      logic [POS_W-1:0]  p;
      logic [DATA_W-1:0] v;
      int                r;
      int                sent;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_mode     = '0;
      req_position = '0;
      req_value    = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         tw  = '{row.status, row.element, row.count, 1'b1};
         send_word(row.mode, row.pos, row.val, row.typed, tw);
      end
      wait_drained();

      for (int ph = 0; ph < PHASES; ph++) begin
         // One filling phase runs against a receiver that has gone quiet.
         if (ph == 3) hold_req = 1'b1;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            r = $urandom_range(0, 99);
            p = POS_W'($urandom);
            if (r < 4) begin
               m = MODE_UNUSED;
            end else if (r < 12) begin
               m = MODE_LIST_ALL;
            end else if ($urandom_range(0, 99) < phase_bias[ph]) begin
               case ($urandom_range(0, 2))
                  0: m = MODE_PUSH_FRONT;
                  1: m = MODE_PUSH_BACK;
                  default: m = MODE_INSERT_AT;
               endcase
               if (m == MODE_INSERT_AT && $urandom_range(0, 9) != 0)
                  p = POS_W'($urandom_range(1, shadow_fill + 1));
            end else begin
               case ($urandom_range(0, 2))
                  0: m = MODE_POP_FRONT;
                  1: m = MODE_POP_BACK;
                  default: m = MODE_REMOVE_AT;
               endcase
               if (m == MODE_REMOVE_AT && $urandom_range(0, 9) != 0)
                  p = POS_W'($urandom_range(1, (shadow_fill > 0) ? shadow_fill : 1));
            end
            case ($urandom_range(0, 9))
               0: v = 32'h8000_0000;
               1: v = 32'h7FFF_FFFF;
               2: v = 32'h0000_0000;
               3: v = 32'hFFFF_FFFF;
               default: v = $urandom;
            endcase
            send_word(m, p, v, 1'b0, '0);
            if (m != MODE_UNUSED) sent++;
         end
         wait_drained();
      end

      repeat (4) @(posedge clock);
      if (owed_words.size() != 0) begin
         report_mismatch("words never delivered", '0, owed_words.size());
      end
      $display("Covered %0d requests and %0d result words, with %0d list walks.",
               requests, words_seen, list_walks);
      $display("The list peaked at %0d of %0d entries and refused %0d writes as full.",
               peak_fill, DEPTH, full_refuse);
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
